@@ src/psg_register_shadow_bank_flush_defines.svh @@
// Assertion macros shared by the shadow bank checker.
`ifndef PSG_REGISTER_SHADOW_BANK_FLUSH_DEFINES_SVH
`define PSG_REGISTER_SHADOW_BANK_FLUSH_DEFINES_SVH

// Property checked on every clock edge outside reset.
`define PSG_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Consequent checked on the edge after the antecedent.
`define PSG_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

@@ src/psg_rsb_pkg.sv @@
// Types, constants and codes of the register shadow bank.
`timescale 1ns / 1ps

package psg_rsb_pkg;

   // Actions of an input transaction
   localparam logic [1:0] ACT_WRITE = 2'd0;
   localparam logic [1:0] ACT_READ  = 2'd1;
   localparam logic [1:0] ACT_FLUSH = 2'd2;
   localparam logic [1:0] ACT_CLEAR = 2'd3;

   // Chip kinds in the configuration register
   localparam logic [1:0] CHIP_NONE     = 2'd0;
   localparam logic [1:0] CHIP_COMPAT   = 2'd1;
   localparam logic [1:0] CHIP_EXPANDED = 2'd2;

   // Result kinds
   localparam logic KIND_READ  = 1'b0;
   localparam logic KIND_WRITE = 1'b1;

   localparam int BANK_A_COUNT = 14;
   localparam int BANK_B_COUNT = 11;
   localparam int BANK_B_BIT   = 16;
   localparam int MODE_REG     = 13;
   localparam int SHADOW_DEPTH = BANK_A_COUNT + BANK_B_COUNT;
   localparam int SLOT_W       = $clog2(SHADOW_DEPTH);
   localparam int DIRTY_W      = BANK_B_BIT + BANK_B_COUNT;

   localparam logic [3:0] MODE_BANK_B = 4'hB;
   localparam logic [3:0] SEL_B_HI    = 4'hB;
   localparam logic [3:0] SEL_A_HI    = 4'hA;
   localparam logic [3:0] MODE_ADDR   = 4'(MODE_REG);

   // Flush sequence positions: select B, bank B regs, select A, bank A regs, mode register
   localparam int POS_SEL_B   = 0;
   localparam int POS_B_FIRST = 1;
   localparam int POS_SEL_A   = POS_B_FIRST + BANK_B_COUNT;
   localparam int POS_A_FIRST = POS_SEL_A + 1;
   localparam int POS_MODE    = POS_A_FIRST + MODE_REG;
   localparam int PEND_W      = POS_MODE + 1;
   localparam int POS_W       = $clog2(PEND_W);

   typedef struct packed {
      logic [1:0] action;
      logic [3:0] reg_index;
      logic [7:0] write_value;
   } req_type;

   typedef struct packed {
      logic       kind;
      logic [3:0] chip_address;
      logic [7:0] value;
      logic       last;
   } rsp_type;

   typedef struct packed {
      logic              clear;
      logic              wr_en;
      logic [SLOT_W-1:0] wr_addr;
      logic [7:0]        wr_data;
      logic              rd_en;
      logic [SLOT_W-1:0] rd_addr;
   } mem_req_type;

endpackage

@@ src/psg_rsb_mem.sv @@
// Shadow register memory with registered read and per-entry valid bits.
`timescale 1ns / 1ps

module psg_rsb_mem (
   input  logic                      clock,
   input  logic                      reset,
   input  psg_rsb_pkg::mem_req_type  mem_req,
   output logic [7:0]                rd_data
);

   logic [7:0]                          mem_array [psg_rsb_pkg::SHADOW_DEPTH];
   logic [psg_rsb_pkg::SHADOW_DEPTH-1:0] valid_ff;
   logic [psg_rsb_pkg::SHADOW_DEPTH-1:0] valid_in;
   logic [7:0]                          rd_data_ff;

   always_comb begin
      valid_in = valid_ff;
      if (mem_req.clear) begin
         valid_in = '0;
      end else if (mem_req.wr_en) begin
         valid_in[mem_req.wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // An entry never written since clear reads as zero
   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem_array[mem_req.wr_addr] <= mem_req.wr_data;
      end
      if (mem_req.rd_en) begin
         rd_data_ff <= valid_ff[mem_req.rd_addr] ? mem_array[mem_req.rd_addr] : 8'h00;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ src/psg_rsb_ctrl.sv @@
// Access sequencer: register writes and reads, dirty tracking and the flush walk.
`timescale 1ns / 1ps

module psg_rsb_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic [1:0]                chip_kind,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  psg_rsb_pkg::req_type      req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output psg_rsb_pkg::rsp_type      rsp_data,
   output psg_rsb_pkg::mem_req_type  mem_req,
   input  logic [7:0]                mem_rd_data
);

   typedef enum logic [1:0] {
      ST_IDLE  = 2'b01,
      ST_FLUSH = 2'b10
   } state_type;

   // Result waiting for the memory read data
   typedef struct packed {
      logic       use_mem;
      logic       kind;
      logic [3:0] chip_address;
      logic [7:0] value;
      logic       last;
   } stage_type;

   state_type                         state_ff, state_in;
   logic [3:0]                        mode_ff, mode_in;
   logic [3:0]                        shape_ff, shape_in;
   logic [psg_rsb_pkg::DIRTY_W-1:0]   dirty_ff, dirty_in;
   logic [psg_rsb_pkg::PEND_W-1:0]    pend_ff, pend_in;
   logic                              s1_valid_ff, s1_valid_in;
   stage_type                         s1_ff, s1_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   psg_rsb_pkg::rsp_type              rsp_ff, rsp_in;

   logic                              out_free;
   logic                              s1_go;
   logic                              s1_room;
   logic                              accept;
   logic                              bank_b;
   logic [3:0]                        idx;
   logic                              is_mode_idx;
   logic                              mapped_a;
   logic                              mapped_b;
   logic [psg_rsb_pkg::SLOT_W-1:0]    slot_a;
   logic [psg_rsb_pkg::SLOT_W-1:0]    slot_b;
   logic [7:0]                        mode_value;
   logic                              chip_ok;
   logic                              switch_bank;
   logic [psg_rsb_pkg::PEND_W-1:0]    pend_init;
   logic [psg_rsb_pkg::POS_W-1:0]     pick;
   logic [psg_rsb_pkg::PEND_W-1:0]    pend_rest;
   logic                              flush_issue;
   stage_type                         flush_stage;
   logic [psg_rsb_pkg::SLOT_W-1:0]    flush_slot;
   stage_type                         read_stage;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign s1_go    = s1_valid_ff && out_free;
   assign s1_room  = !s1_valid_ff || out_free;
   assign req_ready = (state_ff == ST_IDLE) && s1_room;
   assign accept   = req_valid && req_ready;

   assign bank_b      = (mode_ff == psg_rsb_pkg::MODE_BANK_B);
   assign idx         = req_data.reg_index;
   assign is_mode_idx = (idx == psg_rsb_pkg::MODE_ADDR);
   assign mapped_a    = ({1'b0, idx} < 5'(psg_rsb_pkg::BANK_A_COUNT)) && !is_mode_idx;
   assign mapped_b    = ({1'b0, idx} < 5'(psg_rsb_pkg::BANK_B_COUNT));
   assign slot_a      = psg_rsb_pkg::SLOT_W'(idx);
   assign slot_b      = psg_rsb_pkg::SLOT_W'(psg_rsb_pkg::BANK_A_COUNT)
                        + psg_rsb_pkg::SLOT_W'(idx);
   assign mode_value  = {mode_ff, shape_ff};

   assign chip_ok     = (chip_kind == psg_rsb_pkg::CHIP_COMPAT)
                        || (chip_kind == psg_rsb_pkg::CHIP_EXPANDED);
   assign switch_bank = (chip_kind == psg_rsb_pkg::CHIP_EXPANDED) && (mode_ff != 4'h0)
                        && (|dirty_ff[psg_rsb_pkg::DIRTY_W-1:psg_rsb_pkg::BANK_B_BIT]);

   // Work list of the flush, in emission order
   always_comb begin
      pend_init = '0;
      pend_init[psg_rsb_pkg::POS_SEL_B] = switch_bank;
      pend_init[psg_rsb_pkg::POS_SEL_A] = switch_bank;
      for (int r = 0; r < psg_rsb_pkg::BANK_B_COUNT; r++) begin
         pend_init[psg_rsb_pkg::POS_B_FIRST + r] =
            switch_bank && dirty_ff[psg_rsb_pkg::BANK_B_BIT + r];
      end
      for (int r = 0; r < psg_rsb_pkg::MODE_REG; r++) begin
         pend_init[psg_rsb_pkg::POS_A_FIRST + r] = dirty_ff[r];
      end
      // mode register already went out with the bank select writes
      pend_init[psg_rsb_pkg::POS_MODE] = dirty_ff[psg_rsb_pkg::MODE_REG] && !switch_bank;
   end

   // Lowest pending position
   always_comb begin
      pick = '0;
      for (int i = psg_rsb_pkg::PEND_W - 1; i >= 0; i--) begin
         if (pend_ff[i]) begin
            pick = psg_rsb_pkg::POS_W'(i);
         end
      end
      pend_rest = pend_ff;
      pend_rest[pick] = 1'b0;
   end

   assign flush_issue = (state_ff == ST_FLUSH) && s1_room;

   always_comb begin
      flush_stage.kind  = psg_rsb_pkg::KIND_WRITE;
      flush_stage.last  = (pend_rest == '0);
      flush_slot        = '0;
      if (pick == psg_rsb_pkg::POS_W'(psg_rsb_pkg::POS_SEL_B)) begin
         flush_stage.use_mem      = 1'b0;
         flush_stage.chip_address = psg_rsb_pkg::MODE_ADDR;
         flush_stage.value        = {psg_rsb_pkg::SEL_B_HI, shape_ff};
      end else if (pick < psg_rsb_pkg::POS_W'(psg_rsb_pkg::POS_SEL_A)) begin
         flush_stage.use_mem      = 1'b1;
         flush_stage.chip_address = 4'(pick - psg_rsb_pkg::POS_W'(psg_rsb_pkg::POS_B_FIRST));
         flush_stage.value        = 8'h00;
         flush_slot = psg_rsb_pkg::SLOT_W'(pick - psg_rsb_pkg::POS_W'(psg_rsb_pkg::POS_B_FIRST))
                      + psg_rsb_pkg::SLOT_W'(psg_rsb_pkg::BANK_A_COUNT);
      end else if (pick == psg_rsb_pkg::POS_W'(psg_rsb_pkg::POS_SEL_A)) begin
         flush_stage.use_mem      = 1'b0;
         flush_stage.chip_address = psg_rsb_pkg::MODE_ADDR;
         flush_stage.value        = {psg_rsb_pkg::SEL_A_HI, shape_ff};
      end else if (pick < psg_rsb_pkg::POS_W'(psg_rsb_pkg::POS_MODE)) begin
         flush_stage.use_mem      = 1'b1;
         flush_stage.chip_address = 4'(pick - psg_rsb_pkg::POS_W'(psg_rsb_pkg::POS_A_FIRST));
         flush_stage.value        = 8'h00;
         flush_slot = psg_rsb_pkg::SLOT_W'(pick - psg_rsb_pkg::POS_W'(psg_rsb_pkg::POS_A_FIRST));
      end else begin
         flush_stage.use_mem      = 1'b0;
         flush_stage.chip_address = psg_rsb_pkg::MODE_ADDR;
         flush_stage.value        = mode_value;
      end
   end

   always_comb begin
      read_stage.kind         = psg_rsb_pkg::KIND_READ;
      read_stage.chip_address = 4'h0;
      read_stage.last         = 1'b1;
      read_stage.use_mem      = bank_b ? mapped_b : mapped_a;
      read_stage.value        = is_mode_idx ? mode_value : 8'h00;
   end

   always_comb begin
      mem_req       = '0;
      state_in      = state_ff;
      mode_in       = mode_ff;
      shape_in      = shape_ff;
      dirty_in      = dirty_ff;
      pend_in       = pend_ff;
      s1_valid_in   = s1_valid_ff;
      s1_in         = s1_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_in        = rsp_ff;

      if (s1_go) begin
         s1_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_data.action)
                  psg_rsb_pkg::ACT_WRITE: begin
                     mem_req.wr_data = req_data.write_value;
                     if (is_mode_idx) begin
                        mode_in  = req_data.write_value[7:4];
                        shape_in = req_data.write_value[3:0];
                        dirty_in[psg_rsb_pkg::MODE_REG] = 1'b1;
                     end else if (bank_b) begin
                        if (mapped_b) begin
                           mem_req.wr_en   = 1'b1;
                           mem_req.wr_addr = slot_b;
                           dirty_in = dirty_ff | (psg_rsb_pkg::DIRTY_W'(1)
                              << (5'(psg_rsb_pkg::BANK_B_BIT) + {1'b0, idx}));
                        end
                     end else if (mapped_a) begin
                        mem_req.wr_en   = 1'b1;
                        mem_req.wr_addr = slot_a;
                        dirty_in = dirty_ff | (psg_rsb_pkg::DIRTY_W'(1) << idx);
                     end
                  end
                  psg_rsb_pkg::ACT_READ: begin
                     mem_req.rd_en   = read_stage.use_mem;
                     mem_req.rd_addr = bank_b ? slot_b : slot_a;
                     s1_valid_in     = 1'b1;
                     s1_in           = read_stage;
                  end
                  psg_rsb_pkg::ACT_FLUSH: begin
                     // no chip or nothing dirty: dirty bits stay
                     if (chip_ok && (dirty_ff != '0)) begin
                        dirty_in = '0;
                        pend_in  = pend_init;
                        if (pend_init != '0) begin
                           state_in = ST_FLUSH;
                        end
                     end
                  end
                  default: begin
                     mem_req.clear = 1'b1;
                     mode_in       = 4'h0;
                     shape_in      = 4'h0;
                     dirty_in      = '0;
                  end
               endcase
            end
         end
         ST_FLUSH: begin
            if (flush_issue) begin
               mem_req.rd_en   = flush_stage.use_mem;
               mem_req.rd_addr = flush_slot;
               s1_valid_in     = 1'b1;
               s1_in           = flush_stage;
               pend_in         = pend_rest;
               if (pend_rest == '0) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Advance the waiting result into the output register
      if (s1_go) begin
         rsp_valid_in        = 1'b1;
         rsp_in.kind         = s1_ff.kind;
         rsp_in.chip_address = s1_ff.chip_address;
         rsp_in.value        = s1_ff.use_mem ? mem_rd_data : s1_ff.value;
         rsp_in.last         = s1_ff.last;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mode_ff      <= 4'h0;
         shape_ff     <= 4'h0;
         dirty_ff     <= '0;
         pend_ff      <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         shape_ff     <= shape_in;
         dirty_ff     <= dirty_in;
         pend_ff      <= pend_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_ff  <= s1_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

@@ src/psg_register_shadow_bank_flush.sv @@
// Top level of the sound chip register shadow bank with dirty flush.
// Write and clear yield nothing; a read answer passes through the waiting stage and
// the output register, its data taken from the registered read of the shadow memory.
// A flush emits one chip write per cycle while the receiver takes results, up to 26 writes,
// and holds off new transactions until its walk over the dirty bits is done.
// Reset clears control state and all shadow entries at once through valid bits
// (no clearing pass) and sets the chip kind to the expanded chip.
`timescale 1ns / 1ps

module psg_register_shadow_bank_flush (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  psg_rsb_pkg::req_type  req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output psg_rsb_pkg::rsp_type  rsp_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [1:0]            csr_data
);

   logic [1:0]                chip_kind_ff, chip_kind_in;
   psg_rsb_pkg::mem_req_type  mem_req;
   logic [7:0]                mem_rd_data;

   assign csr_ready = 1'b1;

   always_comb begin
      chip_kind_in = chip_kind_ff;
      if (csr_valid && csr_ready) begin
         chip_kind_in = csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chip_kind_ff <= psg_rsb_pkg::CHIP_EXPANDED;
      end else begin
         chip_kind_ff <= chip_kind_in;
      end
   end

   psg_rsb_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .chip_kind   (chip_kind_ff),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .mem_req     (mem_req),
      .mem_rd_data (mem_rd_data)
   );

   psg_rsb_mem u_mem (
      .clock   (clock),
      .reset   (reset),
      .mem_req (mem_req),
      .rd_data (mem_rd_data)
   );

endmodule

@@ src/psg_rsb_checker.sv @@
// Port-level checker for the register shadow bank, bound to the top level.
`timescale 1ns / 1ps
`include "psg_register_shadow_bank_flush_defines.svh"

module psg_rsb_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input psg_rsb_pkg::rsp_type  rsp_data
);

   // Hold a stalled result transaction
   `PSG_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "result changed while stalled")

   // A read answer is a single result at address zero
   `PSG_ASSERT_ALWAYS(a_read_form, !(rsp_valid && (rsp_data.kind == psg_rsb_pkg::KIND_READ)) || (rsp_data.last && (rsp_data.chip_address == 4'h0)), "malformed read answer")

   // Flush writes stay within the chip register map
   `PSG_ASSERT_ALWAYS(a_flush_addr, !(rsp_valid && (rsp_data.kind == psg_rsb_pkg::KIND_WRITE)) || ((rsp_data.chip_address != 4'hE) && (rsp_data.chip_address != 4'hF)), "flush write beyond register map")

endmodule

bind psg_register_shadow_bank_flush psg_rsb_checker u_checker (.*);

@@ test/tb_psg_register_shadow_bank_flush.sv @@
// Testbench for the register shadow bank: random traffic checked against a predictor.
`timescale 1ns / 1ps

module tb_psg_register_shadow_bank_flush;

   localparam logic [1:0] CHIP_UNDEFINED = 2'd3;
   localparam int IDLE_LIMIT = 2000;
   localparam int SETTLE_CYCLES = 40;
   localparam int LONG_HOLD = 300;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   psg_rsb_pkg::req_type  req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   psg_rsb_pkg::rsp_type  rsp_data;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [1:0]            csr_data = psg_rsb_pkg::CHIP_EXPANDED;

   // Predictor state
   logic [7:0]                      shadow_mem [psg_rsb_pkg::SHADOW_DEPTH];
   logic [3:0]                      mode_hi = 4'h0;
   logic [psg_rsb_pkg::DIRTY_W-1:0] dirty_bits = '0;
   logic [1:0]                      chip_sel = psg_rsb_pkg::CHIP_EXPANDED;

   psg_rsb_pkg::req_type pending_reqs [$];
   psg_rsb_pkg::rsp_type answers_due [$];
   int      items_queued = 0;
   int      errors = 0;
   int      idle_cycles = 0;

   // Sender pacing
   int burst_left = 0;
   int gap_left = 0;

   // Receiver pacing
   int hold_asks = 0;
   int holds_served = 0;
   int hold_left = 0;
   int stall_style = 0;
   int style_left = 0;
   int rx_tick = 0;

   psg_register_shadow_bank_flush u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   initial begin
      foreach (shadow_mem[i]) shadow_mem[i] = 8'h00;
   end

   function automatic psg_rsb_pkg::rsp_type chip_write(input logic [3:0] addr,
                                                       input logic [7:0] val);
      return {psg_rsb_pkg::KIND_WRITE, addr, val, 1'b0};
   endfunction

   function automatic logic [7:0] mode_byte();
      return {mode_hi, shadow_mem[psg_rsb_pkg::MODE_REG][3:0]};
   endfunction

   // Update the shadow state for one transaction and queue the results it causes.
   task automatic compute_answers(input psg_rsb_pkg::req_type op);
      logic                  bank_b_sel;
      logic                  switched;
      logic [7:0]            rd_val;
      psg_rsb_pkg::rsp_type  tail;
      int                    n;
      bank_b_sel = (mode_hi == psg_rsb_pkg::MODE_BANK_B);
      switched = 1'b0;
      n = 0;
      case (op.action)
         psg_rsb_pkg::ACT_WRITE: begin
            if (op.reg_index == psg_rsb_pkg::MODE_ADDR) begin
               mode_hi = op.write_value[7:4];
               shadow_mem[psg_rsb_pkg::MODE_REG] = {4'h0, op.write_value[3:0]};
               dirty_bits[psg_rsb_pkg::MODE_REG] = 1'b1;
            end else if (bank_b_sel) begin
               if (op.reg_index < psg_rsb_pkg::BANK_B_COUNT) begin
                  shadow_mem[psg_rsb_pkg::BANK_A_COUNT + op.reg_index] = op.write_value;
                  dirty_bits[psg_rsb_pkg::BANK_B_BIT + op.reg_index] = 1'b1;
               end
            end else if (op.reg_index < psg_rsb_pkg::BANK_A_COUNT) begin
               shadow_mem[op.reg_index] = op.write_value;
               dirty_bits[op.reg_index] = 1'b1;
            end
         end
         psg_rsb_pkg::ACT_READ: begin
            rd_val = 8'h00;
            if (op.reg_index == psg_rsb_pkg::MODE_ADDR) rd_val = mode_byte();
            else if (bank_b_sel) begin
               if (op.reg_index < psg_rsb_pkg::BANK_B_COUNT)
                  rd_val = shadow_mem[psg_rsb_pkg::BANK_A_COUNT + op.reg_index];
            end else if (op.reg_index < psg_rsb_pkg::BANK_A_COUNT)
               rd_val = shadow_mem[op.reg_index];
            answers_due.push_back({psg_rsb_pkg::KIND_READ, 4'h0, rd_val, 1'b1});
         end
         psg_rsb_pkg::ACT_CLEAR: begin
            foreach (shadow_mem[i]) shadow_mem[i] = 8'h00;
            mode_hi = 4'h0;
            dirty_bits = '0;
         end
         default: begin
            // No chip attached, an undefined chip kind or nothing dirty: drop the flush and keep the dirty bits
            if ((chip_sel == psg_rsb_pkg::CHIP_COMPAT || chip_sel == psg_rsb_pkg::CHIP_EXPANDED)
                && dirty_bits != '0) begin
               if (chip_sel == psg_rsb_pkg::CHIP_EXPANDED && mode_hi != 4'h0) begin
                  for (int r = 0; r < psg_rsb_pkg::BANK_B_COUNT; r++) begin
                     if (dirty_bits[psg_rsb_pkg::BANK_B_BIT + r]) begin
                        if (!switched) begin
                           switched = 1'b1;
                           answers_due.push_back(chip_write(psg_rsb_pkg::MODE_ADDR,
                              {psg_rsb_pkg::SEL_B_HI,
                               shadow_mem[psg_rsb_pkg::MODE_REG][3:0]}));
                           n++;
                        end
                        answers_due.push_back(chip_write(4'(r),
                           shadow_mem[psg_rsb_pkg::BANK_A_COUNT + r]));
                        n++;
                     end
                  end
                  if (switched) begin
                     answers_due.push_back(chip_write(psg_rsb_pkg::MODE_ADDR,
                        {psg_rsb_pkg::SEL_A_HI, shadow_mem[psg_rsb_pkg::MODE_REG][3:0]}));
                     n++;
                  end
               end
               for (int r = 0; r < psg_rsb_pkg::BANK_A_COUNT; r++) begin
                  // The bank select write already carried the mode register
                  if (dirty_bits[r] && !(switched && r == psg_rsb_pkg::MODE_REG)) begin
                     answers_due.push_back(chip_write(4'(r),
                        (r == psg_rsb_pkg::MODE_REG) ? mode_byte() : shadow_mem[r]));
                     n++;
                  end
               end
               dirty_bits = '0;
               if (n > 0) begin
                  tail = answers_due.pop_back();
                  tail.last = 1'b1;
                  answers_due.push_back(tail);
               end
            end
         end
      endcase
   endtask

   task automatic check_answer(input psg_rsb_pkg::rsp_type got);
      psg_rsb_pkg::rsp_type want;
      if (answers_due.size() == 0) begin
         errors++;
         $display("%0t: unexpected transaction, expected none, got kind=%0d addr=%0d %s",
                  $time, got.kind, got.chip_address,
                  $sformatf("value=%02h last=%0d", got.value, got.last));
      end else begin
         want = answers_due.pop_front();
         if (got.kind !== want.kind || got.chip_address !== want.chip_address ||
             got.value !== want.value || got.last !== want.last) begin
            errors++;
            $display("%0t: mismatch, expected kind=%0d addr=%0d value=%02h last=%0d, %s",
                     $time, want.kind, want.chip_address, want.value, want.last,
                     $sformatf("got kind=%0d addr=%0d value=%02h last=%0d",
                               got.kind, got.chip_address, got.value, got.last));
         end
      end
   endtask

   // Monitor: configuration, results, requests, and the no-progress watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) chip_sel = csr_data;
         if (rsp_valid && rsp_ready) check_answer(rsp_data);
         if (req_valid && req_ready) compute_answers(req_data);
         if ((csr_valid && csr_ready) || (rsp_valid && rsp_ready) || (req_valid && req_ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb_psg_register_shadow_bank_flush: errors");
            $finish;
         end
      end
   end

   // Driver: bursts of transactions with random gaps
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         burst_left <= 0;
         gap_left <= 0;
      end else if (!req_valid || req_ready) begin
         if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            req_valid <= 1'b0;
         end else if (pending_reqs.size() > 0) begin
            req_valid <= 1'b1;
            req_data <= pending_reqs.pop_front();
            if (burst_left <= 1) begin
               burst_left <= $urandom_range(1, 16);
               gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            end else begin
               burst_left <= burst_left - 1;
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver: rotating stall styles, plus a long hold on request
   always @(posedge clock) begin
      rx_tick <= rx_tick + 1;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_asks != holds_served) begin
         rsp_ready <= 1'b0;
         hold_left <= LONG_HOLD;
         holds_served <= holds_served + 1;
      end else begin
         if (style_left == 0) begin
            stall_style <= $urandom_range(0, 2);
            style_left <= $urandom_range(20, 80);
         end else begin
            style_left <= style_left - 1;
         end
         case (stall_style)
            0: rsp_ready <= 1'b1;
            1: rsp_ready <= 1'($urandom_range(0, 1));
            default: rsp_ready <= (rx_tick % 4 == 0);
         endcase
      end
   end

   task automatic queue_op(input logic [1:0] act, input logic [3:0] idx, input logic [7:0] val);
      pending_reqs.push_back({act, idx, val});
      items_queued++;
   endtask

   // Fill every bank B and bank A register, then flush: the longest result burst
   task automatic queue_full_sweep();
      queue_op(psg_rsb_pkg::ACT_WRITE, psg_rsb_pkg::MODE_ADDR,
               {psg_rsb_pkg::MODE_BANK_B, 4'($urandom_range(0, 15))});
      for (int r = 0; r < psg_rsb_pkg::BANK_B_COUNT; r++)
         queue_op(psg_rsb_pkg::ACT_WRITE, 4'(r), 8'($urandom));
      queue_op(psg_rsb_pkg::ACT_WRITE, psg_rsb_pkg::MODE_ADDR,
               {4'($urandom_range(1, 10)), 4'($urandom_range(0, 15))});
      for (int r = 0; r < psg_rsb_pkg::MODE_REG; r++)
         queue_op(psg_rsb_pkg::ACT_WRITE, 4'(r), 8'($urandom));
      queue_op(psg_rsb_pkg::ACT_FLUSH, 4'($urandom_range(0, 15)), 8'($urandom));
   endtask

   task automatic queue_sequence();
      int         pick;
      int         mode_pick;
      logic [3:0] hi;
      pick = $urandom_range(0, 19);
      if (pick < 14) begin
         // Select a mode, mix writes and reads, then usually flush
         mode_pick = $urandom_range(0, 3);
         hi = (mode_pick == 0) ? 4'h0 :
              (mode_pick == 1) ? psg_rsb_pkg::MODE_BANK_B : 4'($urandom_range(0, 15));
         queue_op(psg_rsb_pkg::ACT_WRITE, psg_rsb_pkg::MODE_ADDR,
                  {hi, 4'($urandom_range(0, 15))});
         repeat ($urandom_range(1, 12))
            queue_op(($urandom_range(0, 3) == 0) ? psg_rsb_pkg::ACT_READ
                                                 : psg_rsb_pkg::ACT_WRITE,
                     4'($urandom_range(0, 15)), 8'($urandom));
         if ($urandom_range(0, 4) != 0)
            queue_op(psg_rsb_pkg::ACT_FLUSH, 4'($urandom_range(0, 15)), 8'($urandom));
      end else if (pick < 16) begin
         queue_full_sweep();
      end else begin
         repeat ($urandom_range(1, 5))
            queue_op(2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)), 8'($urandom));
      end
   endtask

   task automatic queue_random(input int count);
      int target;
      target = items_queued + count;
      while (items_queued < target) queue_sequence();
   endtask

   // Wait for all results, then let any flush walk without results finish
   task automatic wait_idle();
      while (pending_reqs.size() != 0 || req_valid || answers_due.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_chip_kind(input logic [1:0] kind_val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_data <= kind_val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      write_chip_kind(psg_rsb_pkg::CHIP_EXPANDED);

      // Reset contents, unmapped indexes, bank B redirection, expanded flush
      queue_op(psg_rsb_pkg::ACT_READ,  4'd0,  8'h00);
      queue_op(psg_rsb_pkg::ACT_WRITE, 4'd0,  8'hFF);
      queue_op(psg_rsb_pkg::ACT_WRITE, 4'd12, 8'h5A);
      queue_op(psg_rsb_pkg::ACT_WRITE, 4'd14, 8'hFF);
      queue_op(psg_rsb_pkg::ACT_WRITE, 4'd15, 8'h12);
      queue_op(psg_rsb_pkg::ACT_READ,  4'd14, 8'h00);
      queue_op(psg_rsb_pkg::ACT_READ,  4'd15, 8'hFF);
      queue_op(psg_rsb_pkg::ACT_READ,  4'd0,  8'h00);
      queue_op(psg_rsb_pkg::ACT_WRITE, psg_rsb_pkg::MODE_ADDR, {psg_rsb_pkg::MODE_BANK_B, 4'h5});
      queue_op(psg_rsb_pkg::ACT_WRITE, 4'd0,  8'h11);
      queue_op(psg_rsb_pkg::ACT_WRITE, 4'd10, 8'hEE);
      queue_op(psg_rsb_pkg::ACT_WRITE, 4'd11, 8'h77);
      queue_op(psg_rsb_pkg::ACT_WRITE, 4'd12, 8'h66);
      queue_op(psg_rsb_pkg::ACT_READ,  4'd10, 8'h00);
      queue_op(psg_rsb_pkg::ACT_READ,  4'd12, 8'h00);
      queue_op(psg_rsb_pkg::ACT_READ,  psg_rsb_pkg::MODE_ADDR, 8'h00);
      queue_op(psg_rsb_pkg::ACT_FLUSH, 4'd0,  8'h00);
      queue_op(psg_rsb_pkg::ACT_FLUSH, 4'd15, 8'hFF);
      queue_op(psg_rsb_pkg::ACT_WRITE, psg_rsb_pkg::MODE_ADDR, 8'h0C);
      queue_op(psg_rsb_pkg::ACT_READ,  psg_rsb_pkg::MODE_ADDR, 8'h00);
      queue_op(psg_rsb_pkg::ACT_FLUSH, 4'd0,  8'h00);
      queue_op(psg_rsb_pkg::ACT_CLEAR, 4'd0,  8'h00);
      queue_op(psg_rsb_pkg::ACT_READ,  psg_rsb_pkg::MODE_ADDR, 8'h00);
      queue_op(psg_rsb_pkg::ACT_FLUSH, 4'd0,  8'h00);
      queue_random(60);
      wait_idle();

      // Compatible chip: bank B dirty bits are dropped
      write_chip_kind(psg_rsb_pkg::CHIP_COMPAT);
      queue_op(psg_rsb_pkg::ACT_WRITE, psg_rsb_pkg::MODE_ADDR, {psg_rsb_pkg::MODE_BANK_B, 4'h3});
      queue_op(psg_rsb_pkg::ACT_WRITE, 4'd4,  8'h44);
      queue_op(psg_rsb_pkg::ACT_WRITE, psg_rsb_pkg::MODE_ADDR, 8'h13);
      queue_op(psg_rsb_pkg::ACT_WRITE, 4'd2,  8'h22);
      queue_op(psg_rsb_pkg::ACT_FLUSH, 4'd0,  8'h00);
      queue_random(50);
      wait_idle();

      // No chip: flush keeps the dirty bits
      write_chip_kind(psg_rsb_pkg::CHIP_NONE);
      queue_op(psg_rsb_pkg::ACT_WRITE, psg_rsb_pkg::MODE_ADDR, 8'h00);
      queue_op(psg_rsb_pkg::ACT_WRITE, 4'd5,  8'h55);
      queue_op(psg_rsb_pkg::ACT_FLUSH, 4'd0,  8'h00);
      queue_random(40);
      wait_idle();

      write_chip_kind(CHIP_UNDEFINED);
      queue_op(psg_rsb_pkg::ACT_FLUSH, 4'd0,  8'h00);
      queue_random(30);
      wait_idle();

      // Back to the expanded chip: send what was kept, then hold the receiver
      write_chip_kind(psg_rsb_pkg::CHIP_EXPANDED);
      queue_op(psg_rsb_pkg::ACT_FLUSH, 4'd0,  8'h00);
      hold_asks++;
      queue_full_sweep();
      queue_full_sweep();
      queue_random(60);
      wait_idle();

      if (errors == 0)
         $display("tb_psg_register_shadow_bank_flush: clean");
      else
         $display("tb_psg_register_shadow_bank_flush: errors");
      $finish;
   end

endmodule
